FILE: sv/fmenc_pkg.sv
package fmenc_pkg;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_INDEX = 3'd1,
    KIND_ID    = 3'd2,
    KIND_DAM   = 3'd3,
    KIND_DDAM  = 3'd4,
    KIND_CRC   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MODE           = 3'd0,
    CFG_MFM_SYNC       = 3'd1,
    CFG_MFM_INDEX_SYNC = 3'd2,
    CFG_CRC_AFTER_SYNC = 3'd3,
    CFG_FM_INDEX       = 3'd4,
    CFG_FM_ID          = 3'd5,
    CFG_FM_DAM         = 3'd6,
    CFG_FM_DDAM        = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [15:0] CLOCK_CELLS = 16'hAAAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  localparam logic [7:0] MARK_INDEX_BYTE   = 8'hFC;
  localparam logic [7:0] MARK_ID_BYTE      = 8'hFE;
  localparam logic [7:0] MARK_DATA_BYTE    = 8'hFB;
  localparam logic [7:0] MARK_DELETED_BYTE = 8'hF8;

  localparam logic        RST_MODE           = 1'b1;
  localparam logic [15:0] RST_MFM_SYNC       = 16'h4489;
  localparam logic [15:0] RST_MFM_INDEX_SYNC = 16'h5224;
  localparam logic [15:0] RST_CRC_AFTER_SYNC = 16'hCDB4;
  localparam logic [15:0] RST_FM_INDEX       = 16'hF77A;
  localparam logic [15:0] RST_FM_ID          = 16'hF57E;
  localparam logic [15:0] RST_FM_DAM         = 16'hF56F;
  localparam logic [15:0] RST_FM_DDAM        = 16'hF56A;

  typedef struct packed {
    logic        mfm;
    logic [15:0] sync;
    logic [15:0] index_sync;
    logic [15:0] crc_after_sync;
    logic [15:0] fm_index;
    logic [15:0] fm_id;
    logic [15:0] fm_dam;
    logic [15:0] fm_ddam;
  } cfg_t;

  typedef struct packed {
    logic [15:0] cells;
    logic [15:0] fuzzy;
    logic        last;
  } word_t;

  function automatic logic [15:0] spread8(input logic [7:0] b);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i] = b[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] cell_encode(input logic mfm, input logic prior0,
                                              input logic [7:0] b);
    logic [15:0] s;
    logic [15:0] near;
    s    = spread8(b);
    near = {s[14:0], 1'b0} | {1'b0, s[15:1]} | {prior0, 15'b0};
    if (mfm) begin
      return s | (~near & CLOCK_CELLS);
    end
    return s | CLOCK_CELLS;
  endfunction

  function automatic logic [7:0] mark_byte(input kind_e kind);
    logic [7:0] m;
    unique case (kind)
      KIND_INDEX: m = MARK_INDEX_BYTE;
      KIND_ID:    m = MARK_ID_BYTE;
      KIND_DAM:   m = MARK_DATA_BYTE;
      default:    m = MARK_DELETED_BYTE;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/fmenc_item_seq.sv
module fmenc_item_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fmenc_pkg::cfg_t  cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       kind_i,
  input  logic [7:0]       data_byte_i,
  input  logic [7:0]       fuzzy_bits_i,
  input  logic             corrupt_crc_i,
  input  logic             out_ready_i,
  output logic             word_valid_o,
  output fmenc_pkg::word_t word_o
);
  import fmenc_pkg::*;

  logic        item_valid_q, item_valid_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] prior_q, prior_d;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  kind_q;
  logic [7:0]  data_q;
  logic [7:0]  fuzzy_q;
  logic        bad_q;
  logic [7:0]  low_q, low_d;

  kind_e       kind;
  logic [7:0]  byte_v;
  logic [15:0] fz;
  logic [15:0] fixed_word;
  logic [15:0] raw;
  logic [15:0] crc_base;
  logic        use_byte;
  logic        feed;
  logic        last;
  logic        known;
  logic        emit;
  logic        done;
  logic        load;

  always_comb begin
    kind       = kind_e'(kind_q);
    byte_v     = data_q;
    fz         = '0;
    fixed_word = '0;
    crc_base   = crc_q;
    use_byte   = 1'b1;
    feed       = 1'b1;
    last       = 1'b1;
    known      = 1'b1;
    unique case (kind) inside
      KIND_DATA: begin
        fz = spread8(fuzzy_q);
      end
      KIND_INDEX, KIND_ID, KIND_DAM, KIND_DDAM: begin
        byte_v = mark_byte(kind);
        if (cfg_i.mfm) begin
          if (idx_q != 2'd3) begin
            use_byte   = 1'b0;
            feed       = 1'b0;
            last       = 1'b0;
            fixed_word = (kind == KIND_INDEX) ? cfg_i.index_sync : cfg_i.sync;
          end else if (kind != KIND_INDEX) begin
            crc_base = cfg_i.crc_after_sync;
          end
        end else begin
          use_byte = 1'b0;
          crc_base = CRC_INIT;
          unique case (kind)
            KIND_INDEX: fixed_word = cfg_i.fm_index;
            KIND_ID:    fixed_word = cfg_i.fm_id;
            KIND_DAM:   fixed_word = cfg_i.fm_dam;
            default:    fixed_word = cfg_i.fm_ddam;
          endcase
        end
      end
      KIND_CRC: begin
        if (idx_q == 2'd0) begin
          byte_v = crc_q[15:8];
          last   = 1'b0;
        end else begin
          byte_v = low_q;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase

    raw = use_byte ? cell_encode(cfg_i.mfm, prior_q[0], byte_v) : fixed_word;

    emit = item_valid_q && known && out_ready_i;
    done = item_valid_q && (!known || (out_ready_i && last));
    load = in_valid_i && !in_stall_o;

    crc_d   = crc_q;
    prior_d = prior_q;
    low_d   = low_q;
    idx_d   = idx_q;
    if (emit) begin
      if (feed) begin
        crc_d = crc_byte(crc_base, byte_v);
      end
      if (cfg_i.mfm) begin
        prior_d = raw;
      end
      if (kind == KIND_CRC && idx_q == 2'd0) begin
        low_d = crc_q[7:0] ^ {7'b0, bad_q};
      end
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
    if (load) begin
      idx_d = 2'd0;
    end
    item_valid_d = load ? 1'b1 : (done ? 1'b0 : item_valid_q);
  end

  assign in_stall_o   = item_valid_q && !done;
  assign word_valid_o = emit;
  assign word_o.cells = raw & ~fz;
  assign word_o.fuzzy = fz;
  assign word_o.last  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      idx_q        <= '0;
      prior_q      <= '0;
      crc_q        <= CRC_INIT;
    end else begin
      item_valid_q <= item_valid_d;
      idx_q        <= idx_d;
      prior_q      <= prior_d;
      crc_q        <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
    if (load) begin
      kind_q  <= kind_i;
      data_q  <= data_byte_i;
      fuzzy_q <= fuzzy_bits_i;
      bad_q   <= corrupt_crc_i;
    end
  end

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_o && word_o.last |=> idx_q == 2'd0)
    else $error("word index not rewound after the final word");

  a_mid_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_o && !word_o.last |=> item_valid_q && idx_q == $past(idx_q) + 2'd1)
    else $error("item left before its final word");

  a_fm_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_o && !cfg_i.mfm && kind_q != KIND_CRC |-> word_o.last)
    else $error("FM item other than CRC produced more than one word");

endmodule

FILE: sv/fmenc_out_reg.sv
module fmenc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  input  fmenc_pkg::word_t word_i,
  output logic             ready_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [15:0]      cell_word_o,
  output logic [15:0]      fuzzy_word_o,
  output logic             last_word_o
);
  import fmenc_pkg::*;

  logic  valid_q, valid_d;
  word_t word_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = word_valid_i ? 1'b1 : (out_stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_valid_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign cell_word_o  = word_q.cells;
  assign fuzzy_word_o = word_q.fuzzy;
  assign last_word_o  = word_q.last;

endmodule

FILE: sv/fm_mfm_floppy_byte_encoder_unit.sv
// An item's first word passes the item register, then the output register. One word
// leaves per cycle if out_stall_i is low; the single word generator steps through
// each item: a data byte or FM mark gives one word, a CRC item two, MFM marks four.
// Reset clears both stages, loads the CRC with 0xFFFF, clears the previous MFM word
// and restores every configuration register to its default.
module fm_mfm_floppy_byte_encoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmenc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [fmenc_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         kind_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [7:0]                         fuzzy_bits_i,
  input  logic                               corrupt_crc_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        cell_word_o,
  output logic [15:0]                        fuzzy_word_o,
  output logic                               last_word_o
);
  import fmenc_pkg::*;

  cfg_t  cfg_q;
  logic  out_ready;
  logic  word_valid;
  word_t word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mfm            <= RST_MODE;
      cfg_q.sync           <= RST_MFM_SYNC;
      cfg_q.index_sync     <= RST_MFM_INDEX_SYNC;
      cfg_q.crc_after_sync <= RST_CRC_AFTER_SYNC;
      cfg_q.fm_index       <= RST_FM_INDEX;
      cfg_q.fm_id          <= RST_FM_ID;
      cfg_q.fm_dam         <= RST_FM_DAM;
      cfg_q.fm_ddam        <= RST_FM_DDAM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:           cfg_q.mfm            <= cfg_data_i[0];
        CFG_MFM_SYNC:       cfg_q.sync           <= cfg_data_i;
        CFG_MFM_INDEX_SYNC: cfg_q.index_sync     <= cfg_data_i;
        CFG_CRC_AFTER_SYNC: cfg_q.crc_after_sync <= cfg_data_i;
        CFG_FM_INDEX:       cfg_q.fm_index       <= cfg_data_i;
        CFG_FM_ID:          cfg_q.fm_id          <= cfg_data_i;
        CFG_FM_DAM:         cfg_q.fm_dam         <= cfg_data_i;
        CFG_FM_DDAM:        cfg_q.fm_ddam        <= cfg_data_i;
      endcase
    end
  end

  fmenc_item_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .fuzzy_bits_i  (fuzzy_bits_i),
    .corrupt_crc_i (corrupt_crc_i),
    .out_ready_i   (out_ready),
    .word_valid_o  (word_valid),
    .word_o        (word)
  );

  fmenc_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .ready_o      (out_ready),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cell_word_o  (cell_word_o),
    .fuzzy_word_o (fuzzy_word_o),
    .last_word_o  (last_word_o)
  );

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmenc_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 48;
  localparam int unsigned MaxReports   = 20;

  localparam logic [2:0] KindSpareLow  = 3'd6;
  localparam logic [2:0] KindSpareHigh = 3'd7;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i     = '0;
  logic [CfgDataWidth-1:0] cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [2:0]              kind_i        = '0;
  logic [7:0]              data_byte_i   = '0;
  logic [7:0]              fuzzy_bits_i  = '0;
  logic                    corrupt_crc_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic [15:0]             cell_word_o;
  logic [15:0]             fuzzy_word_o;
  logic                    last_word_o;

  cfg_t        enc_cfg;
  logic [15:0] enc_prior;
  logic [15:0] enc_crc;
  word_t       expected_words[$];
  word_t       expected_head;

  int words_in      = 0;
  int words_out     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 15;
  int stall_pct     = 15;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  fm_mfm_floppy_byte_encoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .fuzzy_bits_i  (fuzzy_bits_i),
    .corrupt_crc_i (corrupt_crc_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_word_o   (cell_word_o),
    .fuzzy_word_o  (fuzzy_word_o),
    .last_word_o   (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic cfg_t default_cfg();
    cfg_t s;
    s.mfm            = RST_MODE;
    s.sync           = RST_MFM_SYNC;
    s.index_sync     = RST_MFM_INDEX_SYNC;
    s.crc_after_sync = RST_CRC_AFTER_SYNC;
    s.fm_index       = RST_FM_INDEX;
    s.fm_id          = RST_FM_ID;
    s.fm_dam         = RST_FM_DAM;
    s.fm_ddam        = RST_FM_DDAM;
    return s;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t s;
    s.mfm            = 1'($urandom);
    s.sync           = 16'($urandom);
    s.index_sync     = 16'($urandom);
    s.crc_after_sync = 16'($urandom);
    s.fm_index       = 16'($urandom);
    s.fm_id          = 16'($urandom);
    s.fm_dam         = 16'($urandom);
    s.fm_ddam        = 16'($urandom);
    return s;
  endfunction

  function automatic logic [15:0] interleave8(logic [7:0] b);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i] = b[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // The previous MFM word is kept before fuzzy cells are cleared.
  function automatic void queue_word(logic [15:0] w, logic [15:0] fz);
    word_t e;
    if (enc_cfg.mfm) begin
      enc_prior = w;
    end
    e.cells = w & ~fz;
    e.fuzzy = fz;
    e.last  = 1'b0;
    expected_words.insert(expected_words.size(), e);
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic [7:0] fz);
    logic [15:0] s;
    logic [15:0] near;
    logic [15:0] w;
    s       = interleave8(b);
    enc_crc = crc_update(enc_crc, b);
    if (enc_cfg.mfm) begin
      near = {s[14:0], 1'b0} | {1'b0, s[15:1]} | {enc_prior[0], 15'b0};
      w    = s | (~near & CLOCK_CELLS);
    end else begin
      w = s | CLOCK_CELLS;
    end
    queue_word(w, interleave8(fz));
  endfunction

  function automatic void queue_mark(logic [15:0] sync, logic reload, logic [15:0] fm_word,
                                     logic [7:0] mark);
    if (enc_cfg.mfm) begin
      repeat (3) queue_word(sync, '0);
      if (reload) begin
        enc_crc = enc_cfg.crc_after_sync;
      end
      queue_byte(mark, '0);
    end else begin
      enc_crc = crc_update(CRC_INIT, mark);
      queue_word(fm_word, '0);
    end
  endfunction

  function automatic void predict_cells(logic [2:0] k, logic [7:0] d, logic [7:0] fz,
                                        logic bad);
    int          n;
    logic [15:0] c;
    n = expected_words.size();
    case (k)
      KIND_DATA:  queue_byte(d, fz);
      KIND_INDEX: queue_mark(enc_cfg.index_sync, 1'b0, enc_cfg.fm_index, MARK_INDEX_BYTE);
      KIND_ID:    queue_mark(enc_cfg.sync, 1'b1, enc_cfg.fm_id, MARK_ID_BYTE);
      KIND_DAM:   queue_mark(enc_cfg.sync, 1'b1, enc_cfg.fm_dam, MARK_DATA_BYTE);
      KIND_DDAM:  queue_mark(enc_cfg.sync, 1'b1, enc_cfg.fm_ddam, MARK_DELETED_BYTE);
      KIND_CRC: begin
        c = enc_crc;
        queue_byte(c[15:8], '0);
        queue_byte(c[7:0] ^ {7'b0, bad}, '0);
      end
      default: ;
    endcase
    if (expected_words.size() > n) begin
      expected_words[expected_words.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < MaxReports) begin
      $display("mismatch at cycle %0d: %s: got %h, wanted %h", cycle_count, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_word(logic [2:0] k, logic [7:0] d, logic [7:0] fz, logic bad);
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    data_byte_i   <= d;
    fuzzy_bits_i  <= fz;
    corrupt_crc_i <= bad;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cells(k, d, fz, bad);
    if (k <= KIND_CRC) begin
      words_in++;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:           enc_cfg.mfm = v[0];
      CFG_MFM_SYNC:       enc_cfg.sync = v;
      CFG_MFM_INDEX_SYNC: enc_cfg.index_sync = v;
      CFG_CRC_AFTER_SYNC: enc_cfg.crc_after_sync = v;
      CFG_FM_INDEX:       enc_cfg.fm_index = v;
      CFG_FM_ID:          enc_cfg.fm_id = v;
      CFG_FM_DAM:         enc_cfg.fm_dam = v;
      CFG_FM_DDAM:        enc_cfg.fm_ddam = v;
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t s);
    write_reg(CFG_MODE, {15'($urandom), s.mfm});
    write_reg(CFG_MFM_SYNC, s.sync);
    write_reg(CFG_MFM_INDEX_SYNC, s.index_sync);
    write_reg(CFG_CRC_AFTER_SYNC, s.crc_after_sync);
    write_reg(CFG_FM_INDEX, s.fm_index);
    write_reg(CFG_FM_ID, s.fm_id);
    write_reg(CFG_FM_DAM, s.fm_dam);
    write_reg(CFG_FM_DDAM, s.fm_ddam);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_record(int max_bytes);
    int n;
    n = $urandom_range(0, max_bytes);
    send_word(3'($urandom_range(KIND_INDEX, KIND_DDAM)), 8'($urandom), 8'($urandom),
              1'($urandom));
    repeat (n) begin
      send_word(KIND_DATA, 8'($urandom), ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00,
                1'($urandom));
    end
    send_word(KIND_CRC, 8'($urandom), 8'($urandom), $urandom_range(6) == 0);
  endtask

  task automatic send_mix(int count);
    int target;
    target = words_in + count;
    while (words_in < target) begin
      if ($urandom_range(99) < 80) begin
        send_record(5);
      end else begin
        send_word(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_reset_mfm();
    send_word(KIND_INDEX, 8'hFF, 8'hFF, 1'b1);
    send_word(KIND_ID, 8'h00, 8'hFF, 1'b1);
    send_word(KIND_DATA, 8'h00, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'hFF, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'h00, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'hAA, 8'h55, 1'b0);
    send_word(KIND_DATA, 8'h55, 8'hFF, 1'b0);
    send_word(KIND_DATA, 8'h01, 8'h80, 1'b0);
    send_word(KIND_DATA, 8'h80, 8'h01, 1'b0);
    send_word(KIND_CRC, 8'hFF, 8'hFF, 1'b0);
    send_word(KIND_DAM, 8'h12, 8'h34, 1'b0);
    send_word(KIND_DATA, 8'h5A, 8'h0F, 1'b1);
    send_word(KIND_CRC, 8'h00, 8'h00, 1'b1);
    send_word(KIND_DDAM, 8'h00, 8'h00, 1'b0);
    send_word(KindSpareLow, 8'hFF, 8'hFF, 1'b1);
    send_word(KIND_CRC, 8'h00, 8'h00, 1'b0);
    send_word(KindSpareHigh, 8'h00, 8'h00, 1'b0);
    settle();
  endtask

  task automatic test_fm_marks();
    cfg_t s;
    s     = default_cfg();
    s.mfm = 1'b0;
    load_settings(s);
    send_word(KIND_INDEX, 8'hFF, 8'hFF, 1'b1);
    send_word(KIND_ID, 8'h00, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'h00, 8'h00, 1'b0);
    send_word(KIND_DATA, 8'hFF, 8'hF0, 1'b0);
    send_word(KIND_DAM, 8'h00, 8'h00, 1'b0);
    send_word(KIND_DDAM, 8'h00, 8'h00, 1'b0);
    send_word(KIND_CRC, 8'h00, 8'h00, 1'b1);
    settle();
  endtask

  task automatic test_random_records();
    cfg_t s;
    s = '0;
    load_settings(s);
    send_mix(10);
    settle();
    s = '1;
    load_settings(s);
    send_mix(10);
    settle();
    repeat (2) begin
      load_settings(random_cfg());
      send_mix(10);
      settle();
    end
    load_settings(default_cfg());
    send_mix(10);
    settle();
  endtask

  task automatic test_back_pressure();
    hold_asked++;
    send_idle_pct = 0;
    send_mix(12);
    send_idle_pct = 15;
    settle();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_mix(18);
    settle();
    send_idle_pct = 15;
    stall_pct     = 15;
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles - 1;
      hold_served <= hold_asked;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("cell word with nothing expected", cell_word_o, '0);
      end else begin
        expected_head = expected_words.pop_front();
        words_out++;
        if (cell_word_o !== expected_head.cells) begin
          report_mismatch("cell word", cell_word_o, expected_head.cells);
        end
        if (fuzzy_word_o !== expected_head.fuzzy) begin
          report_mismatch("fuzzy word", fuzzy_word_o, expected_head.fuzzy);
        end
        if (last_word_o !== expected_head.last) begin
          report_mismatch("last flag", {15'b0, last_word_o}, {15'b0, expected_head.last});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    enc_cfg   = default_cfg();
    enc_prior = '0;
    enc_crc   = CRC_INIT;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_mfm();
    test_fm_marks();
    test_random_records();
    test_back_pressure();
    test_no_idle();
    $display("Run covered %0d input words and %0d cell words in FM and MFM, under reset,",
             words_in, words_out);
    $display("extreme and random settings, with a %0d-cycle output hold-off; %0d mismatches.",
             HoldCycles, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
